>>> design/assert_macros.svh
// assertion macros for the tlb page table translate unit
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/tlbpt_pkg.sv
// shared types, constants and helpers of the tlb page table translate unit
// no dependencies
`default_nettype none

package tlbpt_pkg;

    localparam int OFFSET_BITS = 9;
    localparam int VA_W        = 16;
    localparam int PA_W        = 15;
    localparam int VPN_W       = 6;
    localparam int TLB_SETS    = 8;
    localparam int TLB_WAYS    = 2;
    localparam int SET_W       = $clog2(TLB_SETS);
    localparam int TAG_W       = 3;
    localparam int PAGE_W      = 6;
    localparam int PT_ENTRIES  = 64;
    localparam int PT_IDX_W    = $clog2(PT_ENTRIES);
    localparam int OP_W        = 2;

    localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_TLB = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE_PT  = 2'd2;

    typedef enum logic [2:0] {
        ST_TLB_HIT = 3'd0,
        ST_PT_HIT  = 3'd1,
        ST_FAULT   = 3'd2,
        ST_ILLEGAL = 3'd3,
        ST_WRITE   = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_LOOKUP
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [VA_W-1:0]   virtual_address;
        logic [2:0]        tlb_set;
        logic              tlb_way;
        logic [5:0]        table_index;
        logic              entry_valid;
        logic [TAG_W-1:0]  entry_tag;
        logic [PAGE_W-1:0] entry_page;
    } req_t;

    typedef struct packed {
        status_t         status;
        logic [PA_W-1:0] physical_address;
    } rsp_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PAGE_W-1:0] page;
    } tlb_slot_t;

    typedef tlb_slot_t [TLB_WAYS-1:0] tlb_row_t;

    function automatic logic [PA_W-1:0] make_pa(
        input logic [PAGE_W-1:0]      page,
        input logic [OFFSET_BITS-1:0] offset
    );
        logic [PAGE_W+OFFSET_BITS-1:0] full;
        full = {page, offset};
        return full[PA_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/tlbpt_req_if.sv
// request channel: valid, ready and one request word
// depends on tlbpt_pkg
`default_nettype none

interface tlbpt_req_if;
    import tlbpt_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/tlbpt_rsp_if.sv
// response channel: valid, ready and one result word
// depends on tlbpt_pkg
`default_nettype none

interface tlbpt_rsp_if;
    import tlbpt_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/tlb_page_table_translate_unit.sv
// top level: two-way tlb backed by a page table, one ram for each
// depends on tlbpt_pkg, tlbpt_req_if, tlbpt_rsp_if, tlbpt_ram, tlbpt_lookup, assert_macros.svh
// an accepted word and its ram read data are registered, then its result is registered,
// later while the last result is held; no new word is taken until its result is formed
// a tlb write reads the whole set row and writes it back with one way replaced
// reset: asynchronous, clears all valid bits at once; no clearing pass, ram data left as is
`default_nettype none
`include "assert_macros.svh"

module tlb_page_table_translate_unit (
    input  logic         clk,
    input  logic         rst_n,
    tlbpt_req_if.sink    req,
    tlbpt_rsp_if.source  rsp
);
    import tlbpt_pkg::*;

    state_t state_reg, state_next;
    req_t   item_reg;
    logic   out_valid_reg, out_valid_next;
    rsp_t   out_payload_reg, out_payload_next;

    logic [TLB_SETS-1:0][TLB_WAYS-1:0] tlb_valid_reg;
    logic [PT_ENTRIES-1:0]             pt_valid_reg;

    logic                accept;
    logic                done;
    logic [VPN_W-1:0]    req_vpn;
    logic [SET_W-1:0]    tlb_raddr;
    logic [VPN_W-1:0]    item_vpn;
    logic [SET_W-1:0]    item_set;
    logic [SET_W-1:0]    wr_set;
    logic [PT_IDX_W-1:0] wr_idx;
    logic                tlb_we;
    logic                pt_we;
    tlb_row_t            tlb_rdata;
    tlb_row_t            tlb_wdata;
    logic [PAGE_W-1:0]   pt_rdata;
    rsp_t                lk_result;

    assign accept    = req.valid && req.ready;
    assign req_vpn   = req.payload.virtual_address[OFFSET_BITS +: VPN_W];
    assign tlb_raddr = (req.payload.op == OP_WRITE_TLB) ? req.payload.tlb_set[SET_W-1:0]
                                                        : req_vpn[SET_W-1:0];
    assign item_vpn  = item_reg.virtual_address[OFFSET_BITS +: VPN_W];
    assign item_set  = item_vpn[SET_W-1:0];
    assign wr_set    = item_reg.tlb_set[SET_W-1:0];
    assign wr_idx    = item_reg.table_index[PT_IDX_W-1:0];

    always_comb
    begin
        tlb_wdata = tlb_rdata;
        tlb_wdata[item_reg.tlb_way].tag  = item_reg.entry_tag;
        tlb_wdata[item_reg.tlb_way].page = item_reg.entry_page;
    end

    tlbpt_ram #(
        .WIDTH ($bits(tlb_row_t)),
        .DEPTH (TLB_SETS)
    ) u_tlb_ram (
        .clk   (clk),
        .we    (tlb_we),
        .waddr (wr_set),
        .wdata (tlb_wdata),
        .re    (accept),
        .raddr (tlb_raddr),
        .rdata (tlb_rdata)
    );

    tlbpt_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (PT_ENTRIES)
    ) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (wr_idx),
        .wdata (item_reg.entry_page),
        .re    (accept),
        .raddr (req_vpn[PT_IDX_W-1:0]),
        .rdata (pt_rdata)
    );

    tlbpt_lookup u_lookup (
        .item      (item_reg),
        .tlb_row   (tlb_rdata),
        .tlb_valid (tlb_valid_reg[item_set]),
        .pt_page   (pt_rdata),
        .pt_valid  (pt_valid_reg[item_vpn[PT_IDX_W-1:0]]),
        .result    (lk_result)
    );

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_payload_next = out_payload_reg;
        done             = 1'b0;
        req.ready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    done             = 1'b1;
                    out_valid_next   = 1'b1;
                    out_payload_next = lk_result;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign tlb_we = done && item_reg.op == OP_WRITE_TLB;
    assign pt_we  = done && item_reg.op == OP_WRITE_PT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            tlb_valid_reg <= '0;
            pt_valid_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (tlb_we)
            begin
                tlb_valid_reg[wr_set][item_reg.tlb_way] <= item_reg.entry_valid;
            end
            if (pt_we)
            begin
                pt_valid_reg[wr_idx] <= item_reg.entry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_payload_reg <= out_payload_next;
        if (accept)
        begin
            item_reg <= req.payload;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_payload_reg;

    `ASSERT_NEXT(a_accept_to_lookup, clk, rst_n, accept, state_reg == S_LOOKUP)
    `ASSERT_NEXT(a_tlb_valid_written, clk, rst_n, tlb_we,
        tlb_valid_reg[wr_set][item_reg.tlb_way] == item_reg.entry_valid)
    `ASSERT_NEXT(a_illegal_result, clk, rst_n,
        done && item_reg.op == OP_TRANSLATE && item_reg.virtual_address[VA_W-1],
        rsp.valid && rsp.payload.status == ST_ILLEGAL && rsp.payload.physical_address == '0)
endmodule

`default_nettype wire

>>> design/tlbpt_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

>>> design/tlbpt_lookup.sv
// tag compare, page table fallback and result formation for one word
// depends on tlbpt_pkg
`default_nettype none

module tlbpt_lookup (
    input  tlbpt_pkg::req_t                   item,
    input  tlbpt_pkg::tlb_row_t               tlb_row,
    input  logic [tlbpt_pkg::TLB_WAYS-1:0]    tlb_valid,
    input  logic [tlbpt_pkg::PAGE_W-1:0]      pt_page,
    input  logic                              pt_valid,
    output tlbpt_pkg::rsp_t                   result
);
    import tlbpt_pkg::*;

    logic [VPN_W-1:0]       vpn;
    logic [TAG_W-1:0]       tag;
    logic [OFFSET_BITS-1:0] offset;

    always_comb
    begin
        vpn    = item.virtual_address[OFFSET_BITS +: VPN_W];
        tag    = vpn[SET_W +: TAG_W];
        offset = item.virtual_address[OFFSET_BITS-1:0];
        result.status           = ST_WRITE;
        result.physical_address = '0;
        case (item.op)
            OP_TRANSLATE:
            begin
                if (item.virtual_address[VA_W-1])
                begin
                    result.status = ST_ILLEGAL;
                end
                else if (tlb_valid[0] && tlb_row[0].tag == tag)
                begin
                    result.status           = ST_TLB_HIT;
                    result.physical_address = make_pa(tlb_row[0].page, offset);
                end
                else if (tlb_valid[1] && tlb_row[1].tag == tag)
                begin
                    result.status           = ST_TLB_HIT;
                    result.physical_address = make_pa(tlb_row[1].page, offset);
                end
                else if (pt_valid)
                begin
                    result.status           = ST_PT_HIT;
                    result.physical_address = make_pa(pt_page, offset);
                end
                else
                begin
                    result.status = ST_FAULT;
                end
            end
            default:
            begin
                result.status = ST_WRITE;
            end
        endcase
    end
endmodule

`default_nettype wire

>>> bench/tb_tlb_page_table_translate_unit.sv
// testbench of the tlb page table translate unit: directed and random request words,
// each result checked against a model of the tlb and page table kept here
// depends on tlbpt_pkg, tlbpt_req_if, tlbpt_rsp_if and tlb_page_table_translate_unit
`timescale 1ns / 100ps

module tb_tlb_page_table_translate_unit;
    import tlbpt_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 950;
    localparam int IDLE_PCT = 28;

    logic clk;
    logic rst_n;

    tlbpt_req_if req_ch();
    tlbpt_rsp_if rsp_ch();

    tlb_page_table_translate_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic              tlb_valid [TLB_SETS][TLB_WAYS];
    logic [TAG_W-1:0]  tlb_tag   [TLB_SETS][TLB_WAYS];
    logic [PAGE_W-1:0] tlb_page  [TLB_SETS][TLB_WAYS];
    logic              pt_valid  [PT_ENTRIES];
    logic [PAGE_W-1:0] pt_page   [PT_ENTRIES];

    req_t request_queue [$];
    rsp_t answer_queue [$];
    logic [VPN_W-1:0] recent_pages [$];

    int   words_queued = 0;
    int   words_taken = 0;
    int   answers_seen = 0;
    int   error_count = 0;
    logic req_taken = 1'b0;
    logic steady;
    rsp_t got;
    rsp_t want;

    assign steady = (words_taken >= 300) && (words_taken < 500);

    always #10 clk = ~clk;

    function automatic rsp_t translate_or_write(req_t r);
        rsp_t a;
        logic [OFFSET_BITS-1:0] off;
        logic [VPN_W-1:0] vpn;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag_val;
        a.status = ST_WRITE;
        a.physical_address = '0;
        case (r.op)
            OP_TRANSLATE:
            begin
                if (r.virtual_address[VA_W-1]) begin
                    a.status = ST_ILLEGAL;
                end else begin
                    off = r.virtual_address[OFFSET_BITS-1:0];
                    vpn = r.virtual_address[OFFSET_BITS +: VPN_W];
                    set_idx = vpn[SET_W-1:0];
                    tag_val = vpn[VPN_W-1:SET_W];
                    if (tlb_valid[set_idx][0] && tlb_tag[set_idx][0] == tag_val) begin
                        a.status = ST_TLB_HIT;
                        a.physical_address = {tlb_page[set_idx][0], off};
                    end else if (tlb_valid[set_idx][1] && tlb_tag[set_idx][1] == tag_val) begin
                        a.status = ST_TLB_HIT;
                        a.physical_address = {tlb_page[set_idx][1], off};
                    end else if (pt_valid[vpn]) begin
                        a.status = ST_PT_HIT;
                        a.physical_address = {pt_page[vpn], off};
                    end else begin
                        a.status = ST_FAULT;
                    end
                end
            end
            OP_WRITE_TLB:
            begin
                tlb_valid[r.tlb_set][r.tlb_way] = r.entry_valid;
                tlb_tag[r.tlb_set][r.tlb_way] = r.entry_tag;
                tlb_page[r.tlb_set][r.tlb_way] = r.entry_page;
            end
            OP_WRITE_PT:
            begin
                pt_valid[r.table_index] = r.entry_valid;
                pt_page[r.table_index] = r.entry_page;
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, int got_val, int want_val);
        $display("mismatch in %s at result %0d: got %0d, want %0d",
                 what, answers_seen, got_val, want_val);
        error_count++;
    endtask

    task automatic push_word(
        input logic [OP_W-1:0]   op,
        input logic [VA_W-1:0]   va,
        input logic [2:0]        set_idx,
        input logic              way,
        input logic [5:0]        idx,
        input logic              valid_bit,
        input logic [TAG_W-1:0]  tag_val,
        input logic [PAGE_W-1:0] page
    );
        req_t w;
        w.op = op;
        w.virtual_address = va;
        w.tlb_set = set_idx;
        w.tlb_way = way;
        w.table_index = idx;
        w.entry_valid = valid_bit;
        w.entry_tag = tag_val;
        w.entry_page = page;
        request_queue.push_back(w);
        words_queued++;
    endtask

    task automatic drain();
        while (words_taken != words_queued || answer_queue.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!req_ch.valid || req_taken) begin
                if (request_queue.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    req_ch.payload <= request_queue.pop_front();
                    req_ch.valid <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.payload;
                if (answer_queue.size() == 0) begin
                    report_mismatch("unexpected result status", int'(got.status), -1);
                end else begin
                    want = answer_queue.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (got.physical_address !== want.physical_address)
                        report_mismatch("physical address", int'(got.physical_address),
                                        int'(want.physical_address));
                end
                answers_seen++;
            end
            req_taken = req_ch.valid && req_ch.ready;
            if (req_taken) begin
                answer_queue.push_back(translate_or_write(req_ch.payload));
                words_taken++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        req_t w;
        logic [63:0] bits;
        int roll;
        int sub;
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        for (int s = 0; s < TLB_SETS; s++) begin
            for (int k = 0; k < TLB_WAYS; k++) begin
                tlb_valid[s][k] = 1'b0;
                tlb_tag[s][k] = '0;
                tlb_page[s][k] = '0;
            end
        end
        for (int p = 0; p < PT_ENTRIES; p++) begin
            pt_valid[p] = 1'b0;
            pt_page[p] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty tables, range edges
        push_word(OP_TRANSLATE, 16'd0,     3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        push_word(OP_TRANSLATE, 16'd32767, 3'd7, 1'b1, 6'd63, 1'b1, 3'd7, 6'd63);
        push_word(OP_TRANSLATE, 16'd32768, 3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        push_word(OP_TRANSLATE, 16'hFFFF,  3'd7, 1'b1, 6'd63, 1'b1, 3'd7, 6'd63);
        push_word(OP_UNUSED,    16'hFFFF,  3'd7, 1'b1, 6'd63, 1'b1, 3'd7, 6'd63);
        // page table hits at both ends
        push_word(OP_WRITE_PT,  16'hFFFF,  3'd7, 1'b1, 6'd0,  1'b1, 3'd7, 6'd63);
        push_word(OP_TRANSLATE, 16'h01FF,  3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        push_word(OP_WRITE_PT,  16'd0,     3'd0, 1'b0, 6'd63, 1'b1, 3'd0, 6'h15);
        push_word(OP_TRANSLATE, 16'd32767, 3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        // tlb hits, way 0 first, then way 1 once way 0 is cleared
        push_word(OP_WRITE_TLB, 16'd0,     3'd0, 1'b0, 6'd0,  1'b1, 3'd0, 6'd5);
        push_word(OP_TRANSLATE, 16'h0100,  3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        push_word(OP_WRITE_TLB, 16'd0,     3'd0, 1'b1, 6'd0,  1'b1, 3'd0, 6'd9);
        push_word(OP_TRANSLATE, 16'h0000,  3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        push_word(OP_WRITE_TLB, 16'd0,     3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd5);
        push_word(OP_TRANSLATE, 16'h0055,  3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        // tlb over page table, then miss everywhere, then a tlb hit, an unused op and a page table hit
        push_word(OP_WRITE_TLB, 16'd0,     3'd7, 1'b1, 6'd0,  1'b1, 3'd7, 6'd63);
        push_word(OP_TRANSLATE, 16'd32767, 3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        push_word(OP_WRITE_PT,  16'd0,     3'd0, 1'b0, 6'd63, 1'b0, 3'd0, 6'd0);
        push_word(OP_WRITE_TLB, 16'd0,     3'd7, 1'b1, 6'd0,  1'b0, 3'd7, 6'd63);
        push_word(OP_TRANSLATE, 16'd32767, 3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        push_word(OP_WRITE_TLB, 16'hFFFF,  3'd7, 1'b0, 6'd63, 1'b1, 3'd3, 6'd0);
        push_word(OP_TRANSLATE, 16'd16298, 3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        push_word(OP_UNUSED,    16'd0,     3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);
        push_word(OP_WRITE_PT,  16'hFFFF,  3'd7, 1'b1, 6'd42, 1'b1, 3'd7, 6'd33);
        push_word(OP_TRANSLATE, 16'h5400,  3'd0, 1'b0, 6'd0,  1'b0, 3'd0, 6'd0);

        drain();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 2)
                drain();
            bits = {$urandom(), $urandom()};
            w = bits[$bits(req_t)-1:0];
            w.entry_valid = ($urandom_range(99) < 80);
            roll = $urandom_range(99);
            if (roll < 3) begin
                w.op = OP_UNUSED;
            end else if (roll < 23) begin
                w.op = OP_WRITE_TLB;
                recent_pages.push_back({w.entry_tag, w.tlb_set});
            end else if (roll < 41) begin
                w.op = OP_WRITE_PT;
                recent_pages.push_back(w.table_index);
            end else begin
                w.op = OP_TRANSLATE;
                sub = $urandom_range(99);
                w.virtual_address[VA_W-1] = (sub < 10);
                if (sub >= 10 && sub < 75 && recent_pages.size() > 0)
                    w.virtual_address[OFFSET_BITS +: VPN_W] =
                        recent_pages[$urandom_range(recent_pages.size() - 1)];
            end
            if (recent_pages.size() > 8)
                void'(recent_pages.pop_front());
            request_queue.push_back(w);
            words_queued++;
        end

        drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/tlbpt_pkg.sv
design/tlbpt_req_if.sv
design/tlbpt_rsp_if.sv
design/tlbpt_ram.sv
design/tlbpt_lookup.sv
design/tlb_page_table_translate_unit.sv
bench/tb_tlb_page_table_translate_unit.sv
